// ===== rtl/csr_pkg.sv =====
// ----------------------------------------------------------------------------
// csr_pkg
// shared types, constants and helpers of the comb string resonator
// ----------------------------------------------------------------------------
package csr_pkg;

    localparam int LINE_DEPTH_DEF = 2048;

    localparam int Q17_ONE  = 131072;
    localparam int Q28_MAX  = 134217727;
    localparam int Q28_MIN  = -134217728;
    localparam int Q24_MAX  = 8388607;
    localparam int Q24_MIN  = -8388608;
    localparam int GAIN_MAX = 130416;
    localparam int DAMP_MAX = 120586;
    localparam int DISP_MAX = 94372;
    localparam int DISP_MIN_ON = 13;
    localparam int DELAY_MIN = 1024;
    localparam int MAKEUP_K = 78643;
    localparam int SCALE_BASE = 32768;

    localparam int DIV_NW = 54;
    localparam int DIV_DW = 31;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam logic [2:0] REG_DELAY  = 3'd0;
    localparam logic [2:0] REG_GAIN   = 3'd1;
    localparam logic [2:0] REG_DAMP   = 3'd2;
    localparam logic [2:0] REG_DISP   = 3'd3;
    localparam logic [2:0] REG_DRIVE  = 3'd4;
    localparam logic [2:0] REG_MIX    = 3'd5;
    localparam logic [2:0] REG_INVERT = 3'd6;
    localparam logic [2:0] REG_SMOOTH = 3'd7;

    localparam logic [2:0] SM_DELAY = 3'd0;
    localparam logic [2:0] SM_GAIN  = 3'd1;
    localparam logic [2:0] SM_DAMP  = 3'd2;
    localparam logic [2:0] SM_DISP  = 3'd3;
    localparam logic [2:0] SM_DRIVE = 3'd4;
    localparam logic [2:0] SM_MIX   = 3'd5;
    localparam logic [2:0] SM_SIGN  = 3'd6;

    typedef logic [5:0] csr_op_t;

    localparam csr_op_t OP_NOP = 6'd0;
    localparam csr_op_t OP_G0  = 6'd1;
    localparam csr_op_t OP_G6  = 6'd7;
    localparam csr_op_t OP_G7  = 6'd8;
    localparam csr_op_t OP_POS = 6'd9;
    localparam csr_op_t OP_RD0 = 6'd10;
    localparam csr_op_t OP_RD1 = 6'd11;
    localparam csr_op_t OP_RD2 = 6'd12;
    localparam csr_op_t OP_RD3 = 6'd13;
    localparam csr_op_t OP_RD4 = 6'd14;
    localparam csr_op_t OP_C0  = 6'd15;
    localparam csr_op_t OP_C1  = 6'd16;
    localparam csr_op_t OP_C2  = 6'd17;
    localparam csr_op_t OP_C3  = 6'd18;
    localparam csr_op_t OP_C4  = 6'd19;
    localparam csr_op_t OP_C5  = 6'd20;
    localparam csr_op_t OP_L0  = 6'd21;
    localparam csr_op_t OP_L1  = 6'd22;
    localparam csr_op_t OP_L2  = 6'd23;
    localparam csr_op_t OP_A00 = 6'd24;
    localparam csr_op_t OP_A10 = 6'd25;
    localparam csr_op_t OP_A01 = 6'd26;
    localparam csr_op_t OP_A11 = 6'd27;
    localparam csr_op_t OP_S0  = 6'd28;
    localparam csr_op_t OP_S1  = 6'd29;
    localparam csr_op_t OP_S2  = 6'd30;
    localparam csr_op_t OP_S3  = 6'd31;
    localparam csr_op_t OP_S4  = 6'd32;
    localparam csr_op_t OP_S5  = 6'd33;
    localparam csr_op_t OP_F0  = 6'd34;
    localparam csr_op_t OP_F1  = 6'd35;
    localparam csr_op_t OP_F2  = 6'd36;
    localparam csr_op_t OP_M0  = 6'd37;
    localparam csr_op_t OP_M1  = 6'd38;
    localparam csr_op_t OP_M2  = 6'd39;
    localparam csr_op_t OP_CLR = 6'd40;

    typedef struct packed {
        logic [18:0] delay;
        logic [16:0] gain;
        logic [16:0] damp;
        logic [16:0] disp;
        logic [17:0] drive;
        logic [17:0] mix;
        logic        invert;
        logic [17:0] smooth;
    } csr_cfg_t;

    typedef struct packed {
        csr_op_t op;
        logic    load_in;
    } csr_cmd_t;

    typedef struct packed {
        logic ap_en;
        logic div_busy;
    } csr_status_t;

    function automatic logic signed [27:0] sat28(input logic signed [71:0] v);
        logic signed [27:0] r;
        if (v > 72'(Q28_MAX))
            r = 28'(Q28_MAX);
        else if (v < 72'(Q28_MIN))
            r = 28'(Q28_MIN);
        else
            r = 28'(v);
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [71:0] v);
        logic signed [23:0] r;
        if (v > 72'(Q24_MAX))
            r = 24'(Q24_MAX);
        else if (v < 72'(Q24_MIN))
            r = 24'(Q24_MIN);
        else
            r = 24'(v);
        return r;
    endfunction

endpackage

// ===== rtl/csr_ram.sv =====
// ----------------------------------------------------------------------------
// csr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module csr_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/csr_div.sv =====
// ----------------------------------------------------------------------------
// csr_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module csr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [csr_pkg::DIV_NW-1:0]  num,
    input  logic [csr_pkg::DIV_DW-1:0]  den,
    output logic                        busy,
    output logic [csr_pkg::DIV_NW-1:0]  quo
);
    import csr_pkg::*;

    logic              busy_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] q_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    assign shifted = {rem_reg, q_reg[DIV_NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};
    assign busy    = busy_reg;
    assign quo     = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CW'(DIV_NW);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != DIV_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIV_DW'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= shifted[DIV_DW-1:0];
            end
            q_reg <= {q_reg[DIV_NW-2:0], fits};
        end
    end

endmodule

// ===== rtl/csr_dp.sv =====
// ----------------------------------------------------------------------------
// csr_dp
// resonator datapath: smoothers, delay line, interpolator, loop filters,
// saturator and mixer around one shared multiplier and one divider
// ----------------------------------------------------------------------------
module csr_dp #(
    parameter int LINE_DEPTH = csr_pkg::LINE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csr_pkg::csr_cfg_t             cfg,
    input  csr_pkg::csr_cmd_t             cmd,
    input  logic [$clog2(LINE_DEPTH)-1:0] clr_addr,
    input  logic signed [23:0]            in_sample,
    output csr_pkg::csr_status_t          status,
    output logic signed [23:0]            out_sample
);
    import csr_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int DHI = (LINE_DEPTH - 4) * 256;
    localparam logic signed [31:0] SIZE = 32'(LINE_DEPTH * 256);

    logic signed [20:0] sm_reg [7];
    logic signed [20:0] tgt [7];
    logic [AW-1:0]      wi_reg;
    logic signed [27:0] lp_reg;
    logic signed [27:0] in_hist_reg [2];
    logic signed [27:0] out_hist_reg [2];

    logic signed [71:0] p_reg;
    logic signed [49:0] acc_reg;
    logic signed [24:0] x28_reg;
    logic signed [27:0] y_reg [4];
    logic signed [27:0] delayed_reg;
    logic signed [27:0] loop_reg;
    logic [AW-1:0]      i1_reg;
    logic [7:0]         f_reg;
    logic [17:0]        mk_reg;
    logic               neg_reg;
    logic signed [23:0] out_reg;

    logic [17:0] c_eff;
    logic [18:0] t_delay;
    logic [2:0]  mi;
    logic [2:0]  ui;
    logic        ak;
    logic signed [49:0] mul_a;
    logic signed [21:0] mul_b;
    logic               mul_en;
    logic signed [21:0] f_b;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] pos;
    logic [AW-1:0] i0;
    logic [AW-1:0] i2;
    logic [AW-1:0] i3;
    logic signed [20:0] scale;
    logic signed [31:0] u;
    logic [30:0]        umag;
    logic signed [71:0] pmag;
    logic signed [30:0] qs;
    logic signed [30:0] qsig;
    logic signed [27:0] wval;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [27:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [27:0]   ram_rdata;

    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic                div_busy;
    logic [DIV_NW-1:0]   div_quo;

    // clamped targets
    always_comb
    begin
        c_eff = (cfg.smooth > 18'(Q17_ONE)) ? 18'(Q17_ONE) : cfg.smooth;
        if (cfg.delay < 19'(DELAY_MIN))
            t_delay = 19'(DELAY_MIN);
        else if (32'(cfg.delay) > DHI)
            t_delay = 19'(DHI);
        else
            t_delay = cfg.delay;
        tgt[SM_DELAY] = $signed({2'b00, t_delay});
        tgt[SM_GAIN]  = (cfg.gain > 17'(GAIN_MAX)) ? 21'(GAIN_MAX) : $signed({4'b0, cfg.gain});
        tgt[SM_DAMP]  = (cfg.damp > 17'(DAMP_MAX)) ? 21'(DAMP_MAX) : $signed({4'b0, cfg.damp});
        tgt[SM_DISP]  = (cfg.disp > 17'(DISP_MAX)) ? 21'(DISP_MAX) : $signed({4'b0, cfg.disp});
        tgt[SM_DRIVE] = (cfg.drive > 18'(Q17_ONE)) ? 21'(Q17_ONE) : $signed({3'b0, cfg.drive});
        tgt[SM_MIX]   = (cfg.mix > 18'(Q17_ONE)) ? 21'(Q17_ONE) : $signed({3'b0, cfg.mix});
        tgt[SM_SIGN]  = cfg.invert ? -21'(Q17_ONE) : 21'(Q17_ONE);
    end

    assign mi = 3'(cmd.op - OP_G0);
    assign ui = 3'(cmd.op - OP_G0 - 6'd1);
    assign ak = cmd.op == OP_A01 || cmd.op == OP_A11;

    // interpolation
    assign f_b = $signed({14'b0, f_reg});
    assign a0 = -32'(y_reg[0]) + 3 * 32'(y_reg[1]) - 3 * 32'(y_reg[2]) + 32'(y_reg[3]);
    assign a1 = 2 * 32'(y_reg[0]) - 5 * 32'(y_reg[1]) + 4 * 32'(y_reg[2]) - 32'(y_reg[3]);
    assign a2 = 32'(y_reg[2]) - 32'(y_reg[0]);

    always_comb
    begin
        pos = $signed({{(24 - AW){1'b0}}, wi_reg, 8'b0}) - $signed({13'b0, sm_reg[SM_DELAY][18:0]});
        if (pos < 0)
            pos = pos + SIZE;
    end

    assign i0 = (i1_reg == '0) ? AW'(LINE_DEPTH - 1) : i1_reg - 1'b1;
    assign i2 = (i1_reg == AW'(LINE_DEPTH - 1)) ? '0 : i1_reg + 1'b1;
    assign i3 = (i1_reg >= AW'(LINE_DEPTH - 2)) ? i1_reg - AW'(LINE_DEPTH - 2)
                                                : i1_reg + AW'(2);

    // saturator helpers
    assign scale = 21'(SCALE_BASE) + (sm_reg[SM_DRIVE] <<< 2);
    assign u     = 32'(p_reg >>> 17);
    assign umag  = (u < 0) ? 31'(-u) : 31'(u);
    assign pmag  = (p_reg < 0) ? -p_reg : p_reg;
    assign qs    = $signed({1'b0, div_quo[29:0]});
    assign qsig  = neg_reg ? -qs : qs;
    assign wval  = sat28(72'(x28_reg) + (p_reg >>> 17));

    // shared multiplier operand select
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op) inside
            [OP_G0:OP_G6]:
            begin
                mul_a = 50'(tgt[mi] - sm_reg[mi]);
                mul_b = $signed({4'b0, c_eff});
            end
            OP_C0:
            begin
                mul_a = 50'(a0);
                mul_b = f_b;
            end
            OP_C2, OP_C4:
            begin
                mul_a = acc_reg;
                mul_b = f_b;
            end
            OP_L0:
            begin
                mul_a = 50'(delayed_reg);
                mul_b = 22'(21'(Q17_ONE) - sm_reg[SM_DAMP]);
            end
            OP_L1:
            begin
                mul_a = 50'(lp_reg);
                mul_b = 22'(sm_reg[SM_DAMP]);
            end
            OP_A00, OP_A01:
            begin
                mul_a = 50'(out_hist_reg[ak]) - 50'(loop_reg);
                mul_b = 22'(sm_reg[SM_DISP]);
            end
            OP_S0:
            begin
                mul_a = 50'(loop_reg);
                mul_b = 22'(scale);
            end
            OP_S1:
            begin
                mul_a = 50'(sm_reg[SM_DRIVE]);
                mul_b = 22'(MAKEUP_K);
            end
            OP_S3:
            begin
                mul_a = 50'(qsig);
                mul_b = $signed({4'b0, mk_reg});
            end
            OP_F0:
            begin
                mul_a = 50'(loop_reg);
                mul_b = 22'(sm_reg[SM_GAIN]);
            end
            OP_F1:
            begin
                mul_a = 50'(p_reg >>> 17);
                mul_b = 22'(sm_reg[SM_SIGN]);
            end
            OP_M0:
            begin
                mul_a = 50'(x28_reg);
                mul_b = 22'(21'(Q17_ONE) - sm_reg[SM_MIX]);
            end
            OP_M1:
            begin
                mul_a = 50'(delayed_reg);
                mul_b = 22'(sm_reg[SM_MIX]);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // delay line port select
    always_comb
    begin
        ram_we    = cmd.op == OP_CLR || cmd.op == OP_F2;
        ram_waddr = (cmd.op == OP_CLR) ? clr_addr : wi_reg;
        ram_wdata = (cmd.op == OP_CLR) ? '0 : wval;
        case (cmd.op)
            OP_RD0:  ram_raddr = i0;
            OP_RD2:  ram_raddr = i2;
            OP_RD3:  ram_raddr = i3;
            default: ram_raddr = i1_reg;
        endcase
    end

    // divider operand select
    always_comb
    begin
        div_start = cmd.op == OP_S1 || cmd.op == OP_S4;
        if (cmd.op == OP_S1)
        begin
            div_num = {umag[29:0], 24'b0};
            div_den = DIV_DW'(32'd16777216) + umag;
        end
        else
        begin
            div_num = pmag[DIV_NW-1:0];
            div_den = DIV_DW'(scale);
        end
    end

    csr_ram #(
        .WIDTH (28),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    csr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg[SM_DELAY] <= 21'(DELAY_MIN);
            sm_reg[SM_GAIN]  <= '0;
            sm_reg[SM_DAMP]  <= '0;
            sm_reg[SM_DISP]  <= '0;
            sm_reg[SM_DRIVE] <= '0;
            sm_reg[SM_MIX]   <= '0;
            sm_reg[SM_SIGN]  <= 21'(Q17_ONE);
            wi_reg           <= '0;
            lp_reg           <= '0;
            in_hist_reg[0]   <= '0;
            in_hist_reg[1]   <= '0;
            out_hist_reg[0]  <= '0;
            out_hist_reg[1]  <= '0;
        end
        else
        begin
            case (cmd.op) inside
                [OP_G0 + 6'd1:OP_G7]:
                begin
                    sm_reg[ui] <= sm_reg[ui] + 21'(p_reg >>> 17);
                end
                OP_L2:
                begin
                    lp_reg <= sat28((72'(acc_reg) + p_reg) >>> 17);
                end
                OP_A10, OP_A11:
                begin
                    in_hist_reg[ak]  <= loop_reg;
                    out_hist_reg[ak] <= sat28(72'(in_hist_reg[ak]) + (p_reg >>> 17));
                end
                OP_F2:
                begin
                    wi_reg <= (wi_reg == AW'(LINE_DEPTH - 1)) ? '0 : wi_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x28_reg <= $signed({in_sample, 1'b0});
        end
        if (mul_en)
        begin
            p_reg <= mul_a * mul_b;
        end
        if (div_start)
        begin
            neg_reg <= (cmd.op == OP_S1) ? (u < 0) : (p_reg < 0);
        end
        case (cmd.op)
            OP_POS:
            begin
                i1_reg <= pos[AW+7:8];
                f_reg  <= pos[7:0];
            end
            OP_RD1: y_reg[0] <= ram_rdata;
            OP_RD2: y_reg[1] <= ram_rdata;
            OP_RD3: y_reg[2] <= ram_rdata;
            OP_RD4: y_reg[3] <= ram_rdata;
            OP_C1:  acc_reg <= p_reg[49:0] + (50'(a1) <<< 8);
            OP_C3:  acc_reg <= p_reg[49:0] + (50'(a2) <<< 16);
            OP_C5:  delayed_reg <= sat28(72'(y_reg[1]) + (p_reg >>> 25));
            OP_L1:  acc_reg <= p_reg[49:0];
            OP_L2:  loop_reg <= sat28((72'(acc_reg) + p_reg) >>> 17);
            OP_A10, OP_A11:
            begin
                loop_reg <= sat28(72'(in_hist_reg[ak]) + (p_reg >>> 17));
            end
            OP_S2:  mk_reg <= 18'(Q17_ONE) + 18'(p_reg >>> 17);
            OP_S5:  loop_reg <= sat28(72'(qsig));
            OP_M1:  acc_reg <= p_reg[49:0];
            OP_M2:  out_reg <= sat24((72'(acc_reg) + p_reg) >>> 18);
            default:
            begin
            end
        endcase
    end

    assign status.ap_en    = sm_reg[SM_DISP] > 21'(DISP_MIN_ON);
    assign status.div_busy = div_busy;
    assign out_sample      = out_reg;

endmodule

// ===== rtl/csr_ctrl.sv =====
// ----------------------------------------------------------------------------
// csr_ctrl
// sequencer: line clearing after reset, per-sample step program, output slot
// ----------------------------------------------------------------------------
module csr_ctrl #(
    parameter int LINE_DEPTH = csr_pkg::LINE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  csr_pkg::csr_status_t          status,
    output csr_pkg::csr_cmd_t             cmd,
    output logic [$clog2(LINE_DEPTH)-1:0] clr_addr
);
    import csr_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    csr_op_t       pc_reg;
    csr_op_t       pc_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_load;

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        clr_next    = clr_reg;
        cmd.op      = OP_NOP;
        cmd.load_in = 1'b0;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op   = OP_CLR;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(LINE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    pc_next     = OP_G0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if ((pc_reg == OP_S3 || pc_reg == OP_S5) && status.div_busy)
                begin
                    cmd.op = OP_NOP;
                end
                else if (pc_reg == OP_M2)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.op     = OP_M2;
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.op  = pc_reg;
                    pc_next = (pc_reg == OP_L2 && !status.ap_en) ? OP_S0 : pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pc_reg        <= OP_NOP;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign clr_addr  = clr_reg;

endmodule

// ===== rtl/comb_string_resonator_top.sv =====
// ----------------------------------------------------------------------------
// comb_string_resonator_top
// plucked-string comb resonator, one audio sample in, one sample out
// ----------------------------------------------------------------------------
// input samples arrive on the s_axis stream, one request per sample; each
// accepted request yields exactly one mixed sample on the m_axis stream
// loop parameters are set through the apb port while the block is idle; the
// user must keep to this, as the block itself does not enforce it
// a sample runs from the accept cycle through 39 program steps (35 without
// allpasses) and waits on the bit-serial divider, which runs twice in the saturator
// the next sample is taken in the cycle after the result is written; no new
// sample is accepted while the step program still runs for the last one
// after reset the delay line is cleared one entry per cycle, all LINE_DEPTH
// entries, with s_axis_tready low; apb writes are taken meanwhile
// a finished result waits in the output register; a new sample is accepted
// while it waits, and the next result is held back until the first is taken
// ----------------------------------------------------------------------------
module comb_string_resonator_top #(
    parameter int LINE_DEPTH = csr_pkg::LINE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // out_sample
);
    import csr_pkg::*;

    csr_cfg_t           cfg_reg;
    csr_cmd_t           cmd;
    csr_status_t        status;
    logic [$clog2(LINE_DEPTH)-1:0] clr_addr;
    logic signed [23:0] out_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay  <= 19'(DELAY_MIN);
            cfg_reg.gain   <= '0;
            cfg_reg.damp   <= '0;
            cfg_reg.disp   <= '0;
            cfg_reg.drive  <= '0;
            cfg_reg.mix    <= '0;
            cfg_reg.invert <= 1'b0;
            cfg_reg.smooth <= 18'(Q17_ONE);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_DELAY:  cfg_reg.delay  <= pwdata[18:0];
                REG_GAIN:   cfg_reg.gain   <= pwdata[16:0];
                REG_DAMP:   cfg_reg.damp   <= pwdata[16:0];
                REG_DISP:   cfg_reg.disp   <= pwdata[16:0];
                REG_DRIVE:  cfg_reg.drive  <= pwdata[17:0];
                REG_MIX:    cfg_reg.mix    <= pwdata[17:0];
                REG_INVERT: cfg_reg.invert <= pwdata[0];
                REG_SMOOTH: cfg_reg.smooth <= pwdata[17:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_DELAY:  prdata = {13'b0, cfg_reg.delay};
            REG_GAIN:   prdata = {15'b0, cfg_reg.gain};
            REG_DAMP:   prdata = {15'b0, cfg_reg.damp};
            REG_DISP:   prdata = {15'b0, cfg_reg.disp};
            REG_DRIVE:  prdata = {14'b0, cfg_reg.drive};
            REG_MIX:    prdata = {14'b0, cfg_reg.mix};
            REG_INVERT: prdata = {31'b0, cfg_reg.invert};
            REG_SMOOTH: prdata = {14'b0, cfg_reg.smooth};
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    csr_ctrl #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd),
        .clr_addr  (clr_addr)
    );

    csr_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .clr_addr   (clr_addr),
        .in_sample  ($signed(s_axis_tdata)),
        .status     (status),
        .out_sample (out_sample)
    );

    assign m_axis_tdata = out_sample;

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a sample is in flight");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_M2) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over a pending result");

    a_quotient_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_S3 || cmd.op == OP_S5) |-> !status.div_busy)
        else $error("quotient used while divider busy");
`endif

endmodule
